[rtl/burnup_heat_flux_core_assert.svh]
// Assertion helpers for the burnup heat flux core.
`ifndef BURNUP_HEAT_FLUX_CORE_ASSERT_SVH
`define BURNUP_HEAT_FLUX_CORE_ASSERT_SVH

// Plain property, checked on every edge out of reset.
`define BHF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication, checked on every edge out of reset.
`define BHF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/bhf_pkg.sv]
// ----------------------------------------------------------------------------
// bhf_pkg
// Shared constants and tables of the burnup heat flux datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bhf_pkg;

    // register indexes of the configuration port
    localparam logic CFG_TIME_COEFF = 1'b0;
    localparam logic CFG_LATENT     = 1'b1;

    localparam logic [16:0] TC_RESET  = 17'd55797;
    localparam logic [24:0] WLH_RESET = 25'd2500000;

    localparam logic [18:0] MOIST_OFFSET = 19'd36700;
    localparam logic [18:0] ONE_Q16      = 19'd65536;

    // exponent argument and exponential widths
    localparam int ARG_W = 49;
    localparam int EXP_W = 56;
    localparam int SERIES_TERMS = 16;
    localparam int POW_STEPS    = 31;

    // exp(-1) and exp(+1) from the truncated series, Q.32
    localparam logic [33:0] E_NEG = 34'd1580030169;
    localparam logic [33:0] E_POS = 34'd11674931549;

    localparam logic [EXP_W-1:0] EXP_SAT = {EXP_W{1'b1}};

    // floor(2^34 / k), k = 1..16, for the series term divide
    localparam logic [34:0] RECIP [1:16] = '{
        35'd17179869184, 35'd8589934592, 35'd5726623061, 35'd4294967296,
        35'd3435973836,  35'd2863311530, 35'd2454267026, 35'd2147483648,
        35'd1908874353,  35'd1717986918, 35'd1561806289, 35'd1431655765,
        35'd1321528398,  35'd1227133513, 35'd1145324612, 35'd1073741824
    };

    localparam int QUO_W = 48;
    localparam logic [47:0] FLUX_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] FLUX_MIN = 48'h8000_0000_0000;

    // pipeline depths
    localparam int PRE_STAGES  = 5;
    localparam int POST_STAGES = 5;
    localparam int EXP_LAT     = 1 + 3 * SERIES_TERMS + 1 + 2 * POW_STEPS + 1;
    localparam int LATENCY     = PRE_STAGES + ARG_W + EXP_LAT + POST_STAGES + QUO_W + 1;

endpackage

[rtl/burnup_heat_flux_core.sv]
// ----------------------------------------------------------------------------
// burnup_heat_flux_core
// Mean heat flux of exponential fuel burnup, one grid cell per item.
// ----------------------------------------------------------------------------
// Usage:
//   An item (burn time, load, moisture, heat content, interval and arrival
//   times) is taken at each rising edge where start is high and busy low.
//   busy stays low: the pipeline takes one item every cycle.
//   Each item gives one result on o_heat_flux / o_invalid / o_saturated,
//   shown for one cycle with o_valid high. Results come out in order.
//   Latency is set by the pipelined dividers (49 and 48 stages) and
//   the exponential unit (series of 16 terms at three stages each, then
//   up to 31 multiplications at two stages each).
//   The receiver cannot stall; the pipeline never holds.
//   Configuration (time coefficient, latent heat) is written through
//   i_cfg_we / i_cfg_idx / i_cfg_data while no item is in flight.
//   Synchronous reset empties the pipeline and loads the default registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module burnup_heat_flux_core import bhf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        i_burn_time,
    input  logic [23:0]        i_fuel_load,
    input  logic [17:0]        i_moisture_fraction,
    input  logic [24:0]        i_dry_heat_content,
    input  logic [31:0]        i_begin_time,
    input  logic [31:0]        i_end_time,
    input  logic [31:0]        i_arrival_time,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [24:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [47:0] o_heat_flux,
    output logic               o_invalid,
    output logic               o_saturated
);

    logic [16:0] r_time_coeff;
    logic [24:0] r_latent;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_coeff <= TC_RESET;
            r_latent     <= WLH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TIME_COEFF: r_time_coeff <= i_cfg_data[16:0];
                CFG_LATENT:     r_latent     <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // ---- S0: time differences ----
    logic        n0_gb, n0_ge, n0_dtn, n0_inv;
    logic [31:0] n0_magb, n0_mage, n0_dt;

    always_comb begin
        n0_gb   = i_begin_time < i_arrival_time;
        n0_ge   = i_end_time < i_arrival_time;
        n0_magb = n0_gb ? i_arrival_time - i_begin_time : i_begin_time - i_arrival_time;
        n0_mage = n0_ge ? i_arrival_time - i_end_time : i_end_time - i_arrival_time;
        n0_dtn  = i_end_time < i_begin_time;
        n0_dt   = n0_dtn ? i_begin_time - i_end_time : i_end_time - i_begin_time;
        n0_inv  = (i_burn_time == 32'd0) || (i_begin_time == i_end_time);
    end

    logic        r0_v, r0_gb, r0_ge, r0_dtn, r0_inv;
    logic [31:0] r0_magb, r0_mage, r0_dt, r0_bt;
    logic [23:0] r0_load;
    logic [17:0] r0_m;
    logic [24:0] r0_dry;

    // ---- S1..S4 ----
    logic        r1_v, r1_gb, r1_ge, r1_dtn, r1_inv;
    logic [48:0] r1_pb, r1_pe;
    logic [43:0] r1_hp;
    logic [50:0] r1_dd;
    logic [31:0] r1_bt;
    logic [23:0] r1_load;
    logic [24:0] r1_dry;

    logic        r2_v, r2_gb, r2_ge, r2_dtn, r2_inv;
    logic [48:0] r2_pb, r2_pe;
    logic [44:0] r2_heat;
    logic [50:0] r2_dd;
    logic [31:0] r2_bt;
    logic [23:0] r2_load;

    logic        r3_v, r3_gb, r3_ge, r3_dtn, r3_inv;
    logic [48:0] r3_pb, r3_pe;
    logic [46:0] r3_lh0;
    logic [45:0] r3_lh1;
    logic [50:0] r3_dd;
    logic [31:0] r3_bt;

    logic        r4_v, r4_gb, r4_ge, r4_dtn, r4_inv;
    logic [48:0] r4_pb, r4_pe;
    logic [68:0] r4_lh;
    logic [50:0] r4_dd;
    logic [31:0] r4_bt;

    logic [18:0] n1_mo, n1_mq;

    assign n1_mo = {1'b0, r0_m} + MOIST_OFFSET;
    assign n1_mq = {1'b0, r0_m} + ONE_Q16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            r0_v <= start && !busy;
            r1_v <= r0_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_gb   <= n0_gb;
        r0_ge   <= n0_ge;
        r0_dtn  <= n0_dtn;
        r0_inv  <= n0_inv;
        r0_magb <= n0_magb;
        r0_mage <= n0_mage;
        r0_dt   <= n0_dt;
        r0_bt   <= i_burn_time;
        r0_load <= i_fuel_load;
        r0_m    <= i_moisture_fraction;
        r0_dry  <= i_dry_heat_content;

        r1_gb   <= r0_gb;
        r1_ge   <= r0_ge;
        r1_dtn  <= r0_dtn;
        r1_inv  <= r0_inv;
        r1_pb   <= {17'b0, r0_magb} * {32'b0, r_time_coeff};
        r1_pe   <= {17'b0, r0_mage} * {32'b0, r_time_coeff};
        r1_hp   <= {25'b0, n1_mo} * {19'b0, r_latent};
        r1_dd   <= {19'b0, r0_dt} * {32'b0, n1_mq};
        r1_bt   <= r0_bt;
        r1_load <= r0_load;
        r1_dry  <= r0_dry;

        r2_gb   <= r1_gb;
        r2_ge   <= r1_ge;
        r2_dtn  <= r1_dtn;
        r2_inv  <= r1_inv;
        r2_pb   <= r1_pb;
        r2_pe   <= r1_pe;
        r2_heat <= {4'b0, r1_dry, 16'b0} + {1'b0, r1_hp};
        r2_dd   <= r1_dd;
        r2_bt   <= r1_bt;
        r2_load <= r1_load;

        r3_gb   <= r2_gb;
        r3_ge   <= r2_ge;
        r3_dtn  <= r2_dtn;
        r3_inv  <= r2_inv;
        r3_pb   <= r2_pb;
        r3_pe   <= r2_pe;
        r3_lh0  <= {23'b0, r2_load} * {24'b0, r2_heat[22:0]};
        r3_lh1  <= {22'b0, r2_load} * {24'b0, r2_heat[44:23]};
        r3_dd   <= r2_dd;
        r3_bt   <= r2_bt;

        r4_gb   <= r3_gb;
        r4_ge   <= r3_ge;
        r4_dtn  <= r3_dtn;
        r4_inv  <= r3_inv;
        r4_pb   <= r3_pb;
        r4_pe   <= r3_pe;
        r4_lh   <= {22'b0, r3_lh0} + {r3_lh1, 23'b0};
        r4_dd   <= r3_dd;
        r4_bt   <= r3_bt;
    end

    // ---- exponent arguments ----
    localparam int TAG_A = 69 + 51 + 3;
    localparam int TAG_E = 69 + 51 + 1;

    logic             w_va, w_vae;
    logic [ARG_W-1:0] w_argb, w_arge;
    logic [TAG_A-1:0] w_taga;
    logic             w_tage;

    bhf_div #(.W(32), .Q(ARG_W), .TW(TAG_A)) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_v),
        .i_rem   (32'd0),
        .i_low   (r4_pb),
        .i_den   (r4_bt),
        .i_tag   ({r4_lh, r4_dd, r4_dtn, r4_inv, r4_gb}),
        .o_valid (w_va),
        .o_quo   (w_argb),
        .o_tag   (w_taga)
    );

    bhf_div #(.W(32), .Q(ARG_W), .TW(1)) u_div_e (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_v),
        .i_rem   (32'd0),
        .i_low   (r4_pe),
        .i_den   (r4_bt),
        .i_tag   (r4_ge),
        .o_valid (w_vae),
        .o_quo   (w_arge),
        .o_tag   (w_tage)
    );

    // ---- exponentials ----
    logic             w_vxb, w_vxe, w_satb, w_sate, w_xinv;
    logic [EXP_W-1:0] w_eb, w_ee;
    logic [TAG_E-1:0] w_tagx;

    bhf_exp #(.TW(TAG_E)) u_exp_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_va && w_vae),
        .i_arg   (w_argb),
        .i_grow  (w_taga[0]),
        .i_tag   (w_taga[TAG_A-1:2]),
        .o_valid (w_vxb),
        .o_e     (w_eb),
        .o_sat   (w_satb),
        .o_tag   (w_tagx)
    );

    bhf_exp #(.TW(1)) u_exp_e (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_va && w_vae),
        .i_arg   (w_arge),
        .i_grow  (w_tage),
        .i_tag   (w_taga[1]),
        .o_valid (w_vxe),
        .o_e     (w_ee),
        .o_sat   (w_sate),
        .o_tag   (w_xinv)
    );

    // ---- S5..S9: numerator and overflow test ----
    logic        r5_v, r5_neg, r5_sat, r5_inv;
    logic [55:0] r5_df;
    logic [68:0] r5_lh;
    logic [50:0] r5_dd;

    logic        r6_v, r6_neg, r6_sat, r6_inv;
    logic [62:0] r6_p00, r6_p10;
    logic [61:0] r6_p01, r6_p11;
    logic [50:0] r6_dd;

    logic        r7_v, r7_neg, r7_sat, r7_inv;
    logic [97:0] r7_a, r7_b;
    logic [50:0] r7_dd;

    logic         r8_v, r8_neg, r8_sat, r8_inv;
    logic [125:0] r8_num;
    logic [50:0]  r8_dd;

    logic        r9_v, r9_neg, r9_sat, r9_inv, r9_ovf;
    logic [50:0] r9_rem, r9_dd;
    logic [47:0] r9_low;

    logic        n5_lt;
    logic [61:0] n9_top;
    logic        n9_ovf;

    assign n5_lt  = w_eb < w_ee;
    // quotient of the top part by the divisor would not fit in 48 bits
    assign n9_top = r8_num[125:64];
    assign n9_ovf = n9_top >= {11'b0, r8_dd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r9_v <= 1'b0;
        end else begin
            r5_v <= w_vxb && w_vxe;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
            r9_v <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_df  <= n5_lt ? w_ee - w_eb : w_eb - w_ee;
        r5_neg <= n5_lt ^ w_tagx[0];
        r5_sat <= w_satb || w_sate;
        r5_inv <= w_xinv;
        r5_lh  <= w_tagx[TAG_E-1:52];
        r5_dd  <= w_tagx[51:1];

        r6_p00 <= {35'b0, r5_df[27:0]} * {28'b0, r5_lh[34:0]};
        r6_p01 <= {34'b0, r5_df[27:0]} * {28'b0, r5_lh[68:35]};
        r6_p10 <= {35'b0, r5_df[55:28]} * {28'b0, r5_lh[34:0]};
        r6_p11 <= {34'b0, r5_df[55:28]} * {28'b0, r5_lh[68:35]};
        r6_neg <= r5_neg;
        r6_sat <= r5_sat;
        r6_inv <= r5_inv;
        r6_dd  <= r5_dd;

        r7_a   <= {35'b0, r6_p00} + {1'b0, r6_p01, 35'b0};
        r7_b   <= {35'b0, r6_p10} + {1'b0, r6_p11, 35'b0};
        r7_neg <= r6_neg;
        r7_sat <= r6_sat;
        r7_inv <= r6_inv;
        r7_dd  <= r6_dd;

        r8_num <= {28'b0, r7_a} + {r7_b, 28'b0};
        r8_neg <= r7_neg;
        r8_sat <= r7_sat;
        r8_inv <= r7_inv;
        r8_dd  <= r7_dd;

        r9_rem <= n9_ovf ? '0 : n9_top[50:0];
        r9_low <= r8_num[63:16];
        r9_ovf <= n9_ovf;
        r9_neg <= r8_neg;
        r9_sat <= r8_sat;
        r9_inv <= r8_inv;
        r9_dd  <= r8_dd;
    end

    // ---- final divide ----
    logic              w_vq;
    logic [QUO_W-1:0]  w_quo;
    logic [3:0]        w_tagq;

    bhf_div #(.W(51), .Q(QUO_W), .TW(4)) u_div_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r9_v),
        .i_rem   (r9_rem),
        .i_low   (r9_low),
        .i_den   (r9_dd),
        .i_tag   ({r9_neg, r9_sat, r9_ovf, r9_inv}),
        .o_valid (w_vq),
        .o_quo   (w_quo),
        .o_tag   (w_tagq)
    );

    // ---- clamp and sign ----
    logic        n_big;
    logic [47:0] n_flux;

    always_comb begin
        if (w_tagq[3]) begin
            n_big  = w_tagq[1] || (w_quo > FLUX_MIN);
            n_flux = n_big ? FLUX_MIN : 48'd0 - w_quo;
        end else begin
            n_big  = w_tagq[1] || (w_quo > FLUX_MAX);
            n_flux = n_big ? FLUX_MAX : w_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_vq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tagq[0]) begin
            o_heat_flux <= '0;
            o_invalid   <= 1'b1;
            o_saturated <= 1'b0;
        end else begin
            o_heat_flux <= $signed(n_flux);
            o_invalid   <= 1'b0;
            o_saturated <= w_tagq[2] || n_big;
        end
    end

endmodule

[rtl/bhf_div.sv]
// ----------------------------------------------------------------------------
// bhf_div
// Pipelined restoring divider, one quotient bit per stage, with sideband tag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bhf_div import bhf_pkg::*; #(
    parameter int W  = 32,
    parameter int Q  = 49,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [W-1:0]  i_rem,
    input  logic [Q-1:0]  i_low,
    input  logic [W-1:0]  i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [Q-1:0]  o_quo,
    output logic [TW-1:0] o_tag
);

    logic          r_v   [0:Q-1];
    logic [W-1:0]  r_rem [0:Q-1];
    logic [W-1:0]  r_den [0:Q-1];
    logic [Q-1:0]  r_low [0:Q-1];
    logic [TW-1:0] r_tag [0:Q-1];

    for (genvar j = 0; j < Q; j++) begin : g_stage
        logic          w_v;
        logic [W-1:0]  w_rem;
        logic [W-1:0]  w_den;
        logic [Q-1:0]  w_low;
        logic [TW-1:0] w_tag;
        logic [W:0]    w_t;
        logic [W:0]    w_d;
        logic          w_ge;

        if (j == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_rem = i_rem;
            assign w_den = i_den;
            assign w_low = i_low;
            assign w_tag = i_tag;
        end else begin : g_next
            assign w_v   = r_v[j-1];
            assign w_rem = r_rem[j-1];
            assign w_den = r_den[j-1];
            assign w_low = r_low[j-1];
            assign w_tag = r_tag[j-1];
        end

        // low word shifts dividend bits out at the top and quotient bits in below
        assign w_t  = {w_rem, w_low[Q-1]};
        assign w_ge = w_t >= {1'b0, w_den};
        assign w_d  = w_t - {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j] <= w_ge ? w_d[W-1:0] : w_t[W-1:0];
            r_low[j] <= {w_low[Q-2:0], w_ge};
            r_den[j] <= w_den;
            r_tag[j] <= w_tag;
        end
    end

    assign o_valid = r_v[Q-1];
    assign o_quo   = r_low[Q-1];
    assign o_tag   = r_tag[Q-1];

endmodule

[rtl/bhf_exp.sv]
// ----------------------------------------------------------------------------
// bhf_exp
// Pipelined exp(+x) / exp(-x): series on the fraction, then repeated
// multiplication by exp(+-1) for the integer part.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bhf_exp import bhf_pkg::*; #(
    parameter int TW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [ARG_W-1:0] i_arg,
    input  logic             i_grow,
    input  logic [TW-1:0]    i_tag,
    output logic             o_valid,
    output logic [EXP_W-1:0] o_e,
    output logic             o_sat,
    output logic [TW-1:0]    o_tag
);

    typedef struct packed {
        logic          v;
        logic [15:0]   f;
        logic [4:0]    n;
        logic          neg;
        logic          zero;
        logic          satf;
        logic [TW-1:0] tag;
    } t_ctl;

    t_ctl n_ctl;

    always_comb begin
        n_ctl.v    = i_valid;
        n_ctl.f    = i_arg[15:0];
        n_ctl.n    = i_arg[20:16];
        n_ctl.neg  = !i_grow;
        // decay by 32 whole units or more is zero; growth by 16 or more clamps
        n_ctl.zero = !i_grow && (|i_arg[ARG_W-1:21]);
        n_ctl.satf = i_grow && (|i_arg[ARG_W-1:20]);
        n_ctl.tag  = i_tag;
    end

    // ---- series stages ----
    t_ctl               r_c    [0:SERIES_TERMS];
    logic [32:0]        r_term [0:SERIES_TERMS];
    logic signed [35:0] r_acc  [0:SERIES_TERMS];
    t_ctl               r_ca   [0:SERIES_TERMS-1];
    t_ctl               r_cb   [0:SERIES_TERMS-1];
    logic signed [35:0] r_acca [0:SERIES_TERMS-1];
    logic signed [35:0] r_accb [0:SERIES_TERMS-1];
    logic [32:0]        r_x    [0:SERIES_TERMS-1];
    logic [32:0]        r_xb   [0:SERIES_TERMS-1];
    logic [32:0]        r_q0   [0:SERIES_TERMS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c[0] <= '0;
        end else begin
            r_c[0] <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_term[0] <= 33'h1_0000_0000;
        r_acc[0]  <= 36'sh1_0000_0000;
    end

    for (genvar k = 0; k < SERIES_TERMS; k++) begin : g_term
        localparam int K = k + 1;
        localparam logic [37:0] KV = 38'(K);
        localparam bit ODD = (K % 2) == 1;

        logic [48:0]        w_prod;
        logic [67:0]        w_m;
        logic [37:0]        w_qk;
        logic [37:0]        w_r;
        logic [32:0]        w_q;
        logic signed [35:0] w_acc;

        assign w_prod = {16'b0, r_term[k]} * {33'b0, r_c[k].f};
        assign w_m    = {35'b0, r_x[k]} * {33'b0, RECIP[K]};
        assign w_qk   = {5'b0, r_q0[k]} * KV;
        assign w_r    = {5'b0, r_xb[k]} - w_qk;
        // reciprocal estimate is low by at most one
        assign w_q    = (w_r >= KV) ? r_q0[k] + 33'd1 : r_q0[k];

        always_comb begin
            if (r_cb[k].neg && ODD) begin
                w_acc = r_accb[k] - $signed({3'b0, w_q});
            end else begin
                w_acc = r_accb[k] + $signed({3'b0, w_q});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ca[k]  <= '0;
                r_cb[k]  <= '0;
                r_c[k+1] <= '0;
            end else begin
                r_ca[k]  <= r_c[k];
                r_cb[k]  <= r_ca[k];
                r_c[k+1] <= r_cb[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[k]      <= w_prod[48:16];
            r_acca[k]   <= r_acc[k];
            r_q0[k]     <= w_m[66:34];
            r_xb[k]     <= r_x[k];
            r_accb[k]   <= r_acca[k];
            r_term[k+1] <= w_q;
            r_acc[k+1]  <= w_acc;
        end
    end

    // ---- integer part: up to POW_STEPS multiplications ----
    t_ctl             r_pc  [0:POW_STEPS];
    logic [EXP_W-1:0] r_pe  [0:POW_STEPS];
    t_ctl             r_pca [0:POW_STEPS-1];
    logic [EXP_W-1:0] r_pea [0:POW_STEPS-1];
    logic [65:0]      r_pl  [0:POW_STEPS-1];
    logic [57:0]      r_ph  [0:POW_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc[0] <= '0;
        end else begin
            r_pc[0] <= r_c[SERIES_TERMS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pe[0] <= r_acc[SERIES_TERMS][35] ? '0
                 : {22'b0, r_acc[SERIES_TERMS][33:0]};
    end

    for (genvar j = 0; j < POW_STEPS; j++) begin : g_pow
        localparam logic [4:0] JV = 5'(j);

        logic [33:0] w_base;
        logic [57:0] w_sum;

        assign w_base = r_pc[j].neg ? E_NEG : E_POS;
        assign w_sum  = r_ph[j] + {24'b0, r_pl[j][65:32]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pca[j]  <= '0;
                r_pc[j+1] <= '0;
            end else begin
                r_pca[j]  <= r_pc[j];
                r_pc[j+1] <= r_pca[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_pl[j]    <= {34'b0, r_pe[j][31:0]} * {32'b0, w_base};
            r_ph[j]    <= {34'b0, r_pe[j][EXP_W-1:32]} * {24'b0, w_base};
            r_pea[j]   <= r_pe[j];
            r_pe[j+1]  <= (JV < r_pca[j].n) ? w_sum[EXP_W-1:0] : r_pea[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_pc[POW_STEPS].v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pc[POW_STEPS].zero) begin
            o_e <= '0;
        end else if (r_pc[POW_STEPS].satf) begin
            o_e <= EXP_SAT;
        end else begin
            o_e <= r_pe[POW_STEPS];
        end
        o_sat <= r_pc[POW_STEPS].satf;
        o_tag <= r_pc[POW_STEPS].tag;
    end

endmodule

[rtl/bhf_checker.sv]
// ----------------------------------------------------------------------------
// bhf_checker
// Port-level checks of the burnup heat flux core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "burnup_heat_flux_core_assert.svh"

module bhf_checker import bhf_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic [31:0]        i_burn_time,
    input logic [31:0]        i_begin_time,
    input logic [31:0]        i_end_time,
    input logic               o_valid,
    input logic signed [47:0] o_heat_flux,
    input logic               o_invalid,
    input logic               o_saturated
);

    // one mark per accepted item, aged by the pipeline depth
    logic [LATENCY-1:0] r_sh;
    // invalid condition of each input slot, aged alongside
    logic [LATENCY-1:0] r_inv;
    logic               w_take;
    logic               w_inv;
    logic               w_zero;

    assign w_take = start && !busy;
    assign w_inv  = (i_burn_time == 32'd0) || (i_begin_time == i_end_time);
    assign w_zero = (o_heat_flux == 48'sd0) && !o_saturated;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh  <= '0;
            r_inv <= '0;
        end else begin
            r_sh  <= {r_sh[LATENCY-2:0], w_take};
            r_inv <= {r_inv[LATENCY-2:0], w_inv};
        end
    end

    `BHF_ASSERT(a_one_result, i_clk, i_rst_n, o_valid == r_sh[LATENCY-1], "strobe off items")

    `BHF_ASSERT_IMPL(a_inv_zero, i_clk, i_rst_n, o_valid && o_invalid, w_zero, "invalid not zero")

    `BHF_ASSERT_IMPL(a_inv_src, i_clk, i_rst_n, o_valid, o_invalid == r_inv[LATENCY-1], "stray invalid")

endmodule

bind burnup_heat_flux_core bhf_checker u_bhf_checker (.*);
